// ===== rtl/gpioe_pkg.sv =====
// ----------------------------------------------------------------------------
// gpioe_pkg
// Shared types and constants for the GPIO controller with edge interrupts:
// request command codes, register word indexes and field widths.
// ----------------------------------------------------------------------------
package gpioe_pkg;

   localparam int FIELD_W = 30;
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   // Register word indexes (byte offset divided by four).
   localparam logic [IDX_W-1:0] IDX_LEVEL = 7'd1;
   localparam logic [IDX_W-1:0] IDX_DIR   = 7'd7;
   localparam logic [IDX_W-1:0] IDX_SET   = 7'd13;
   localparam logic [IDX_W-1:0] IDX_CLEAR = 7'd19;
   localparam logic [IDX_W-1:0] IDX_RISE  = 7'd25;
   localparam logic [IDX_W-1:0] IDX_FALL  = 7'd31;
   localparam logic [IDX_W-1:0] IDX_IMASK = 7'd43;
   localparam logic [IDX_W-1:0] IDX_ISTAT = 7'd49;
   localparam logic [IDX_W-1:0] IDX_WMASK = 7'd64;
   localparam logic [IDX_W-1:0] IDX_WSTAT = 7'd70;

endpackage

// ===== rtl/gpio_controller_edge_irq_core.sv =====
// ----------------------------------------------------------------------------
// gpio_controller_edge_irq_core
// GPIO controller with edge-detecting interrupt and wake status, driven by
// register read/write requests and pin sample ticks.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid / req_ready  command, reg_index,
//                                                write_data, pin_levels
//   rsp_      out         rsp_valid / rsp_ready  read_data, pin_drive,
//                                                pin_output_enable, irq_out,
//                                                wake_out
//
// Every request produces exactly one response, registered and presented in the cycle after acceptance.
// A request is taken in every cycle in which the response register is empty
// or is being emptied at the same edge, so the sustained rate is one request
// per cycle; the single response register is the only storage on the path.
// When the response side stalls, requests stall behind it; no request is
// ever dropped.
// Reset is synchronous and active high: all control and register state is
// cleared, and no request is taken while reset is asserted.
//
module gpio_controller_edge_irq_core
   import gpioe_pkg::*;
#(
   parameter int NUM_PINS = 30
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [IDX_W-1:0]   req_reg_index,
   input  logic [FIELD_W-1:0] req_write_data,
   input  logic [FIELD_W-1:0] req_pin_levels,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [FIELD_W-1:0] rsp_read_data,
   output logic [FIELD_W-1:0] rsp_pin_drive,
   output logic [FIELD_W-1:0] rsp_pin_output_enable,
   output logic               rsp_irq_out,
   output logic               rsp_wake_out
);

   // Only pins that both exist and fit in a payload field hold state; any
   // higher bit is dropped on input and reads back as zero.
   localparam int STORE_W = (NUM_PINS < FIELD_W) ? NUM_PINS : FIELD_W;

   typedef logic [STORE_W-1:0] pins_type;

   // Register file.
   pins_type out_latch_ff,   out_latch_in;
   pins_type dir_bits_ff,    dir_bits_in;
   pins_type rise_en_ff,     rise_en_in;
   pins_type fall_en_ff,     fall_en_in;
   pins_type irq_mask_ff,    irq_mask_in;
   pins_type irq_status_ff,  irq_status_in;
   pins_type wake_mask_ff,   wake_mask_in;
   pins_type wake_status_ff, wake_status_in;
   pins_type prev_pins_ff,   prev_pins_in;

   // Response register.
   logic               rsp_valid_ff,     rsp_valid_in;
   logic [FIELD_W-1:0] rsp_read_data_ff, rsp_read_data_in;
   logic [FIELD_W-1:0] rsp_drive_ff,     rsp_drive_in;
   logic [FIELD_W-1:0] rsp_oe_ff,        rsp_oe_in;
   logic               rsp_irq_ff,       rsp_irq_in;
   logic               rsp_wake_ff,      rsp_wake_in;

   logic     req_accept;
   pins_type wdata;
   pins_type pins;
   pins_type edges;
   pins_type rd_value;

   // The response register may be refilled at the same edge at which it is
   // emptied, which is what allows one request per cycle.
   assign req_ready  = !reset && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   assign wdata = req_write_data[STORE_W-1:0];
   assign pins  = req_pin_levels[STORE_W-1:0];

   // Enabled edges against the previous sample, regardless of mask.
   assign edges = ((pins & ~prev_pins_ff) & rise_en_ff)
                | ((~pins & prev_pins_ff) & fall_en_ff);

   // Read mux: write-only and unmapped indexes return zero.
   always_comb begin
      unique case (req_reg_index)
         IDX_LEVEL: rd_value = prev_pins_ff;
         IDX_DIR:   rd_value = dir_bits_ff;
         IDX_RISE:  rd_value = rise_en_ff;
         IDX_FALL:  rd_value = fall_en_ff;
         IDX_IMASK: rd_value = irq_mask_ff;
         IDX_ISTAT: rd_value = irq_status_ff;
         IDX_WMASK: rd_value = wake_mask_ff;
         IDX_WSTAT: rd_value = wake_status_ff;
         default:   rd_value = '0;
      endcase
   end

   // Next state of the register file for the accepted request.
   always_comb begin
      out_latch_in   = out_latch_ff;
      dir_bits_in    = dir_bits_ff;
      rise_en_in     = rise_en_ff;
      fall_en_in     = fall_en_ff;
      irq_mask_in    = irq_mask_ff;
      irq_status_in  = irq_status_ff;
      wake_mask_in   = wake_mask_ff;
      wake_status_in = wake_status_ff;
      prev_pins_in   = prev_pins_ff;
      if (req_accept) begin
         unique case (req_command)
            CMD_WRITE: begin
               unique case (req_reg_index)
                  IDX_DIR:   dir_bits_in    = wdata;
                  IDX_SET:   out_latch_in   = out_latch_ff | wdata;
                  IDX_CLEAR: out_latch_in   = out_latch_ff & ~wdata;
                  IDX_RISE:  rise_en_in     = wdata;
                  IDX_FALL:  fall_en_in     = wdata;
                  IDX_IMASK: irq_mask_in    = wdata;
                  IDX_ISTAT: irq_status_in  = irq_status_ff & ~wdata;
                  IDX_WMASK: wake_mask_in   = wdata;
                  IDX_WSTAT: wake_status_in = wake_status_ff & ~wdata;
                  default: begin
                  end
               endcase
            end
            CMD_TICK: begin
               irq_status_in  = irq_status_ff | edges;
               wake_status_in = wake_status_ff | (edges & wake_mask_ff);
               prev_pins_in   = pins;
            end
            default: begin
               // Reads leave state alone, as does the unused command code.
            end
         endcase
      end
   end

   // Response contents show the state after the request has taken effect.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_read_data_in = rsp_read_data_ff;
      rsp_drive_in     = rsp_drive_ff;
      rsp_oe_in        = rsp_oe_ff;
      rsp_irq_in       = rsp_irq_ff;
      rsp_wake_in      = rsp_wake_ff;
      if (req_accept) begin
         rsp_valid_in     = 1'b1;
         rsp_read_data_in = (req_command == CMD_READ) ? FIELD_W'(rd_value) : '0;
         rsp_drive_in     = FIELD_W'(out_latch_in);
         rsp_oe_in        = FIELD_W'(dir_bits_in);
         rsp_irq_in       = |(irq_status_in & irq_mask_in);
         rsp_wake_in      = |wake_status_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_latch_ff   <= '0;
         dir_bits_ff    <= '0;
         rise_en_ff     <= '0;
         fall_en_ff     <= '0;
         irq_mask_ff    <= '0;
         irq_status_ff  <= '0;
         wake_mask_ff   <= '0;
         wake_status_ff <= '0;
         prev_pins_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         out_latch_ff   <= out_latch_in;
         dir_bits_ff    <= dir_bits_in;
         rise_en_ff     <= rise_en_in;
         fall_en_ff     <= fall_en_in;
         irq_mask_ff    <= irq_mask_in;
         irq_status_ff  <= irq_status_in;
         wake_mask_ff   <= wake_mask_in;
         wake_status_ff <= wake_status_in;
         prev_pins_ff   <= prev_pins_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Response payload needs no reset; it is qualified by rsp_valid.
   always_ff @(posedge clock) begin
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_drive_ff     <= rsp_drive_in;
      rsp_oe_ff        <= rsp_oe_in;
      rsp_irq_ff       <= rsp_irq_in;
      rsp_wake_ff      <= rsp_wake_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = rsp_read_data_ff;
   assign rsp_pin_drive         = rsp_drive_ff;
   assign rsp_pin_output_enable = rsp_oe_ff;
   assign rsp_irq_out           = rsp_irq_ff;
   assign rsp_wake_out          = rsp_wake_ff;

endmodule

// ===== rtl/gpioe_checker.sv =====
// ----------------------------------------------------------------------------
// gpioe_checker
// Port-level checks for the GPIO controller, bound to gpio_controller_edge_irq_core.
// ----------------------------------------------------------------------------
module gpioe_checker
   import gpioe_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [CMD_W-1:0]   req_command,
   input logic [IDX_W-1:0]   req_reg_index,
   input logic [FIELD_W-1:0] req_write_data,
   input logic [FIELD_W-1:0] req_pin_levels,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [FIELD_W-1:0] rsp_read_data,
   input logic [FIELD_W-1:0] rsp_pin_drive,
   input logic [FIELD_W-1:0] rsp_pin_output_enable,
   input logic               rsp_irq_out,
   input logic               rsp_wake_out
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_pin_drive) && $stable(rsp_pin_output_enable)
         && $stable(rsp_irq_out) && $stable(rsp_wake_out))
      else $error("stalled response changed");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Every accepted request shows up as a response in the next cycle.
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   // Only reads return register data.
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command != CMD_READ |=> rsp_read_data == '0)
      else $error("non-read request returned read data");

   // An empty response register never holds off requests.
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

endmodule

bind gpio_controller_edge_irq_core gpioe_checker u_gpioe_checker (.*);
